@@ hdl/lspbs_pkg.sv @@
`default_nettype none
package lspbs_pkg;

  // Section table geometry
  localparam int unsigned MAX_SECTIONS = 16;
  localparam int unsigned SEC_IDX_W    = $clog2(MAX_SECTIONS);
  localparam int unsigned SEC_CNT_W    = 5;
  localparam int unsigned LED_W        = 8;
  localparam int unsigned BIT_W        = 5;
  localparam int unsigned COLOR_W      = 24;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned SCALE_W      = 7;
  localparam int unsigned PROD_W       = BYTE_W + SCALE_W;

  // Protocol bits per LED and brightness full scale
  localparam logic [BIT_W-1:0]   BITS_PER_LED = 5'd24;
  localparam logic [SCALE_W-1:0] FULL_SCALE   = 7'd100;

  // Division by 100 as multiply by 5243 and shift by 19, exact below 43699
  localparam int unsigned        RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP_100   = 13'd5243;
  localparam int unsigned        RECIP_SHIFT = 19;
  localparam int unsigned        QPROD_W     = PROD_W + RECIP_W;

  // Reset values of the configuration registers
  localparam logic [SEC_CNT_W-1:0] RST_SECTION_COUNT = 5'd0;
  localparam logic [SCALE_W-1:0]   RST_BRIGHTNESS    = 7'd31;
  localparam logic [7:0]           RST_DUTY_ZERO     = 8'd30;
  localparam logic [7:0]           RST_DUTY_ONE      = 8'd60;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SECTION_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_ZERO     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_ONE      = 2'd3;

  // Input item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [3:0]         section_slot;
    logic [LED_W-1:0]   led_total;
    logic [COLOR_W-1:0] section_color;
  } in_item_t;

  typedef struct packed {
    logic [7:0] duty;
    logic       frame_end;
  } out_item_t;

endpackage
`default_nettype wire

@@ hdl/led_section_pwm_bit_stream_unit.sv @@
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_ready_o  in_data_i  (in_item_t)
// out       output     out_valid_o/out_ready_i out_data_o (out_item_t)
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One item is accepted per cycle while in_ready_o is high; cursors and the
// section table update at the transfer. A fetch that emits a bit reaches
// out_data_o through registers: the colour byte pick, the brightness multiply
// and the reciprocal-of-100 multiply each end in one, the first loaded at the transfer.
// Reset clears the section table, the cursors and the pipeline, and loads register defaults.
// A stalled output holds the pipeline; bubbles collapse, so input stalls only when full.
`default_nettype none
module led_section_pwm_bit_stream_unit
  import lspbs_pkg::*;
(
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output out_item_t             out_data_o,
  input  wire                   cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire [CFG_DATA_W-1:0]  cfg_data_i
);

  // Configuration registers
  logic [SEC_CNT_W-1:0] section_count_q;
  logic [SCALE_W-1:0]   brightness_q;
  logic [7:0]           duty_zero_q;
  logic [7:0]           duty_one_q;

  // Section table and cursors
  logic [COLOR_W-1:0]   colors_q  [MAX_SECTIONS];
  logic [LED_W-1:0]     lengths_q [MAX_SECTIONS];
  logic [SEC_IDX_W-1:0] sec_q, sec_d;
  logic [LED_W-1:0]     led_q, led_d;
  logic [BIT_W-1:0]     bit_q, bit_d;

  // Pipeline registers
  logic                 s1_valid_q;
  logic [BYTE_W-1:0]    s1_byte_q;
  logic [SCALE_W-1:0]   s1_scale_q;
  logic [2:0]           s1_bitpos_q;
  logic                 s1_fe_q;
  logic                 s2_valid_q;
  logic [PROD_W-1:0]    s2_prod_q;
  logic [2:0]           s2_bitpos_q;
  logic                 s2_fe_q;
  logic                 out_valid_q;
  out_item_t            out_q;

  logic in_xfer, cfg_xfer, out_go, s2_go, s1_go;
  logic is_write, is_fetch, emit_d, fe_d;
  logic [SEC_CNT_W-1:0] count;
  logic [SEC_CNT_W-1:0] sec_ext, sec_next;
  logic [LED_W-1:0]     cur_len;
  logic [COLOR_W-1:0]   cur_color;
  logic [LED_W:0]       led_next;
  logic [BIT_W-1:0]     bit_next;
  logic                 later_nz;
  logic [BYTE_W-1:0]    byte_d;
  logic [SCALE_W-1:0]   scale_d;
  logic [QPROD_W-1:0]   qprod;
  logic [BYTE_W-1:0]    scaled;
  logic                 bit_val;

  // Handshake: each stage moves when the next one is free or moving
  assign out_go      = !out_valid_q || out_ready_i;
  assign s2_go       = !s2_valid_q || out_go;
  assign s1_go       = !s1_valid_q || s2_go;
  assign in_ready_o  = s1_go;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign is_write = in_xfer && (in_data_i.kind == KIND_WRITE);
  assign is_fetch = in_xfer && (in_data_i.kind == KIND_FETCH);

  // Clamp the section count and brightness
  assign count   = (section_count_q > SEC_CNT_W'(MAX_SECTIONS)) ?
                   SEC_CNT_W'(MAX_SECTIONS) : section_count_q;
  assign scale_d = (brightness_q > FULL_SCALE) ? FULL_SCALE : brightness_q;

  assign sec_ext   = {1'b0, sec_q};
  assign sec_next  = sec_ext + 1'b1;
  assign cur_len   = lengths_q[sec_q];
  assign cur_color = colors_q[sec_q];
  assign led_next  = {1'b0, led_q} + 1'b1;
  assign bit_next  = bit_q + 1'b1;

  // Flag any non-empty section after the current one and below the count
  always_comb begin
    later_nz = 1'b0;
    for (int s = 0; s < MAX_SECTIONS; s++) begin
      if (lengths_q[s] != '0 && SEC_CNT_W'(s) > sec_ext && SEC_CNT_W'(s) < count) begin
        later_nz = 1'b1;
      end
    end
  end

  // Select the colour byte for the current bit
  always_comb begin
    case (bit_q[4:3])
      2'd0:    byte_d = cur_color[23:16];
      2'd1:    byte_d = cur_color[15:8];
      2'd2:    byte_d = cur_color[7:0];
      default: byte_d = '0;
    endcase
  end

  // Advance the cursors for a fetch; reset them on a table write
  always_comb begin
    sec_d  = sec_q;
    led_d  = led_q;
    bit_d  = bit_q;
    emit_d = 1'b0;
    fe_d   = 1'b0;
    if (is_fetch) begin
      if (sec_ext >= count) begin
        sec_d = '0;
        led_d = '0;
        bit_d = '0;
      end else if (led_q >= cur_len) begin
        // skip an empty or exhausted section
        sec_d = (sec_next >= count) ? '0 : sec_next[SEC_IDX_W-1:0];
        led_d = '0;
        bit_d = '0;
      end else begin
        emit_d = 1'b1;
        bit_d  = bit_next;
        if (bit_next >= BITS_PER_LED) begin
          bit_d = '0;
          led_d = led_next[LED_W-1:0];
          if (led_next >= {1'b0, cur_len}) begin
            led_d = '0;
            if (!later_nz) begin
              fe_d  = 1'b1;
              sec_d = '0;
            end else begin
              sec_d = (sec_next >= count) ? '0 : sec_next[SEC_IDX_W-1:0];
            end
          end
        end
      end
    end else if (is_write && ({1'b0, in_data_i.section_slot} < 5'(MAX_SECTIONS))) begin
      sec_d = '0;
      led_d = '0;
      bit_d = '0;
    end
  end

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      section_count_q <= RST_SECTION_COUNT;
      brightness_q    <= RST_BRIGHTNESS;
      duty_zero_q     <= RST_DUTY_ZERO;
      duty_one_q      <= RST_DUTY_ONE;
    end else if (cfg_xfer) begin
      case (cfg_index_i)
        REG_SECTION_COUNT: section_count_q <= cfg_data_i[SEC_CNT_W-1:0];
        REG_BRIGHTNESS:    brightness_q    <= cfg_data_i[SCALE_W-1:0];
        REG_DUTY_ZERO:     duty_zero_q     <= cfg_data_i;
        REG_DUTY_ONE:      duty_one_q      <= cfg_data_i;
        default:           ;
      endcase
    end
  end

  // Store section entries and advance the cursors
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < MAX_SECTIONS; s++) begin
        colors_q[s]  <= '0;
        lengths_q[s] <= '0;
      end
      sec_q <= '0;
      led_q <= '0;
      bit_q <= '0;
    end else begin
      if (is_write && ({1'b0, in_data_i.section_slot} < 5'(MAX_SECTIONS))) begin
        colors_q[in_data_i.section_slot[SEC_IDX_W-1:0]]  <= in_data_i.section_color;
        lengths_q[in_data_i.section_slot[SEC_IDX_W-1:0]] <= in_data_i.led_total;
      end
      sec_q <= sec_d;
      led_q <= led_d;
      bit_q <= bit_d;
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_go) s1_valid_q <= emit_d;
      if (s2_go) s2_valid_q <= s1_valid_q;
      if (out_go) out_valid_q <= s2_valid_q;
    end
  end

  // Divide the scaled byte by 100 and pick the bit
  assign qprod   = {{RECIP_W{1'b0}}, s2_prod_q} * {{PROD_W{1'b0}}, RECIP_100};
  assign scaled  = qprod[RECIP_SHIFT +: BYTE_W];
  assign bit_val = scaled[s2_bitpos_q];

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      s1_byte_q   <= byte_d;
      s1_scale_q  <= scale_d;
      s1_bitpos_q <= 3'd7 - bit_q[2:0];
      s1_fe_q     <= fe_d;
    end
    if (s2_go) begin
      s2_prod_q   <= PROD_W'(s1_byte_q) * PROD_W'(s1_scale_q);
      s2_bitpos_q <= s1_bitpos_q;
      s2_fe_q     <= s1_fe_q;
    end
    if (out_go) begin
      out_q.duty      <= bit_val ? duty_one_q : duty_zero_q;
      out_q.frame_end <= s2_fe_q;
    end
  end

endmodule
`default_nettype wire

@@ hdl/lspbs_checker.sv @@
`default_nettype none
module lspbs_checker
  import lspbs_pkg::*;
(
  input wire            clk_i,
  input wire            rst_ni,
  input wire            in_valid_i,
  input wire            in_ready_o,
  input wire            out_valid_o,
  input wire            out_ready_i,
  input out_item_t      out_data_o,
  input wire            cfg_ready_o
);

  // Configuration port never back-pressures
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("cfg_ready_o low");

  // Input stalls only behind a stalled output
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without output back-pressure");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

  // No result right out of reset
  a_reset_empty: assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind led_section_pwm_bit_stream_unit lspbs_checker u_lspbs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .cfg_ready_o (cfg_ready_o)
);
`default_nettype wire
